### rtl/core/two_peak_range_detector_core_defines.svh
// assertion macros for the two-peak range detector core
// used by modules that declare clk and rst_n; no other dependencies
`ifndef TWO_PEAK_RANGE_DETECTOR_CORE_DEFINES_SVH
`define TWO_PEAK_RANGE_DETECTOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TPRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TPRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tprd_pkg.sv
// shared types and constants of the two-peak range detector core
// no dependencies
package tprd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned COUNT_W    = 2;
  localparam int unsigned DIST_W     = 28;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_SEL_B  = 2;   // paddr bit that picks the register
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [COUNT_W-1:0] PEAKS_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] PEAKS_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] PEAKS_TWO  = 2'd2;

  typedef enum logic {
    REG_PEAK_THRESHOLD = 1'b0,
    REG_DISTANCE_SCALE = 1'b1
  } reg_idx_t;

  // one sample beat held in the input register
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } beat_t;

  // status of the pending record result
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } res_stat_t;

endpackage

### rtl/core/tprd_peak_track.sv
// record state and peak decision for the two-peak range detector
// depends on tprd_pkg
module tprd_peak_track
  import tprd_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] threshold,
  input  beat_t                      beat,
  input  logic                       beat_go,
  input  logic                       res_take,
  output res_stat_t                  res,
  output logic [$clog2(MAX_LENGTH)-1:0] diff
);

  localparam int unsigned IDX_W = $clog2(MAX_LENGTH);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_LENGTH - 1);

  logic signed [SAMPLE_W-1:0] prev_r, older_r;
  logic [IDX_W-1:0]           pos_r, first_r, second_r;
  logic                       have_prev_r;
  logic [COUNT_W-1:0]         cnt_r;

  logic                       res_valid_r;
  logic [COUNT_W-1:0]         res_cnt_r;
  logic [IDX_W-1:0]           res_diff_r;

  logic                       prev_peak, cur_peak;
  logic [IDX_W-1:0]           idx;
  logic [COUNT_W-1:0]         cnt1, cnt2;
  logic [IDX_W-1:0]           first1, second1, first2, second2;
  logic [IDX_W-1:0]           diff_nxt;

  always_comb begin
    // previous sample judged now that its right neighbour is here
    prev_peak = have_prev_r && (prev_r >= threshold) && (prev_r >= beat.sample) &&
                ((pos_r == '0) || (prev_r >= older_r));
    if (!have_prev_r) begin
      idx = '0;
    end else if (pos_r < MAX_IDX) begin
      idx = pos_r + IDX_W'(1);
    end else begin
      idx = MAX_IDX;
    end

    cnt1    = cnt_r;
    first1  = first_r;
    second1 = second_r;
    if (prev_peak) begin
      if (cnt_r == PEAKS_NONE) begin
        first1 = pos_r;
        cnt1   = PEAKS_ONE;
      end else if (cnt_r == PEAKS_ONE) begin
        second1 = pos_r;
        cnt1    = PEAKS_TWO;
      end
    end

    // final sample has no right neighbour
    cur_peak = beat.last && (beat.sample >= threshold) &&
               (!have_prev_r || (beat.sample >= prev_r));
    cnt2    = cnt1;
    first2  = first1;
    second2 = second1;
    if (cur_peak) begin
      if (cnt1 == PEAKS_NONE) begin
        first2 = idx;
        cnt2   = PEAKS_ONE;
      end else if (cnt1 == PEAKS_ONE) begin
        second2 = idx;
        cnt2    = PEAKS_TWO;
      end
    end

    diff_nxt = (second2 >= first2) ? (second2 - first2) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      older_r     <= '0;
      pos_r       <= '0;
      have_prev_r <= 1'b0;
      cnt_r       <= PEAKS_NONE;
      first_r     <= '0;
      second_r    <= '0;
    end else if (beat_go) begin
      if (beat.last) begin
        prev_r      <= '0;
        older_r     <= '0;
        pos_r       <= '0;
        have_prev_r <= 1'b0;
        cnt_r       <= PEAKS_NONE;
        first_r     <= '0;
        second_r    <= '0;
      end else begin
        older_r     <= prev_r;
        prev_r      <= beat.sample;
        pos_r       <= idx;
        have_prev_r <= 1'b1;
        cnt_r       <= cnt1;
        first_r     <= first1;
        second_r    <= second1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (beat_go && beat.last) begin
      res_valid_r <= 1'b1;
    end else if (res_take) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_go && beat.last) begin
      res_cnt_r  <= cnt2;
      res_diff_r <= (cnt2 == PEAKS_TWO) ? diff_nxt : '0;
    end
  end

  assign res.valid = res_valid_r;
  assign res.count = res_cnt_r;
  assign diff      = res_diff_r;

endmodule

### rtl/core/two_peak_range_detector_core.sv
// top level of the two-peak range detector: stream ports, apb registers, distance stage
// depends on tprd_pkg, tprd_peak_track and two_peak_range_detector_core_defines.svh
//
// usage
//   in_*  : one echo record as a run of samples, in_tdata[15:0] signed q1.15,
//           in_tlast on the final sample of the record
//   out_* : one beat per record, out_tdata[1:0] peak count (saturated at two),
//           out_tdata[29:2] peak distance in 1/256 m, zero unless two peaks
//   cfg_* : apb registers, 0x0 peak threshold (signed), 0x4 distance scale
// throughput: one sample per clock, sustained; a sample is taken every cycle
//   the pipeline is free, including while a finished result waits on out_tready
// the result of a record reaches out_tdata through the input register, the
//   peak tracker and the multiply stage, each registered, in that order
// the distance multiply (index difference times scale) sits in the last stage
// reset (rst_n low, synchronous) clears both registers, the record state and
//   all valid flags; a record in flight is dropped
// when out_tready is low the output holds; one more result can wait in the
//   tracker, after which the last sample of a record stalls in_tready
// registers should only be written while no record is in flight
module two_peak_range_detector_core
  import tprd_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream, tdata: sample[15:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  // result stream, tdata: target_count[1:0], target_distance[29:2], zero[31:30]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // apb configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  `include "two_peak_range_detector_core_defines.svh"

  localparam int unsigned IDX_W  = $clog2(MAX_LENGTH);
  localparam int unsigned PROD_W = IDX_W + SCALE_W;
  // wide enough to see any bit above the distance field
  localparam int unsigned EXT_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W + 1;

  // configuration registers
  logic signed [SAMPLE_W-1:0] thresh_r;
  logic [SCALE_W-1:0]         scale_r;
  reg_idx_t                   cfg_sel;
  logic                       cfg_wr;

  // input register
  logic  in_valid_r;
  beat_t beat_r;
  logic  beat_go;

  // tracker result
  res_stat_t        res;
  logic [IDX_W-1:0] diff;
  logic             res_take;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_free;

  logic [PROD_W-1:0] prod;
  logic [EXT_W-1:0]  prod_ext;
  logic [DIST_W-1:0] dist_nxt;

  // apb: no wait states, register picked by one address bit
  assign cfg_pready = 1'b1;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[CFG_SEL_B]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      scale_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PEAK_THRESHOLD: thresh_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_DISTANCE_SCALE: scale_r  <= cfg_pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PEAK_THRESHOLD: cfg_prdata = {{(CFG_DATA_W-SAMPLE_W){1'b0}}, thresh_r};
      REG_DISTANCE_SCALE: cfg_prdata = {{(CFG_DATA_W-SCALE_W){1'b0}}, scale_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // handshake chain: output frees the tracker result slot, which frees a last beat
  assign out_free  = !out_valid_r || out_tready;
  assign res_take  = res.valid && out_free;
  // a non-last beat only updates record state, so it never waits
  assign beat_go   = in_valid_r && (!beat_r.last || !res.valid || res_take);
  assign in_tready = !in_valid_r || beat_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (beat_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.sample <= in_tdata[SAMPLE_W-1:0];
      beat_r.last   <= in_tlast;
    end
  end

  tprd_peak_track #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .threshold(thresh_r),
    .beat     (beat_r),
    .beat_go  (beat_go),
    .res_take (res_take),
    .res      (res),
    .diff     (diff)
  );

  // distance = index difference * scale, saturated to the field width
  always_comb begin
    prod     = PROD_W'(diff) * PROD_W'(scale_r);
    prod_ext = EXT_W'(prod);
    dist_nxt = (|prod_ext[EXT_W-1:DIST_W]) ? {DIST_W{1'b1}} : prod_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_cnt_r  <= res.count;
      out_dist_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-DIST_W-COUNT_W){1'b0}}, out_dist_r, out_cnt_r};

  // a processed last beat always leaves a pending result behind
  `TPRD_ASSERT_NEXT(a_last_makes_result, beat_go && beat_r.last, res.valid,
                    "last beat processed without a pending result")
  // a distance only ever comes with two peaks
  `TPRD_ASSERT_NOW(a_dist_needs_two, out_valid_r && (out_cnt_r != PEAKS_TWO),
                   out_dist_r == '0, "nonzero distance with fewer than two peaks")
  // input stalls only behind a last beat that has no free result slot
  `TPRD_ASSERT_NOW(a_stall_cause, !in_tready,
                   in_valid_r && beat_r.last && res.valid && !out_free,
                   "input stalled without a full result path")
  // count never exceeds its saturation value
  `TPRD_ASSERT_NOW(a_count_range, res.valid, res.count <= PEAKS_TWO,
                   "peak count beyond two")

endmodule
